### sv/ehrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event history ring package
// Shared field widths, operation codes, payload and entry types, and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ehrd_pkg;

   // Field widths fixed by the transaction formats.
   localparam int OP_W     = 2;
   localparam int ACTION_W = 8;
   localparam int AREA_W   = 8;
   localparam int TIME_W   = 32;
   localparam int AGE_W    = 4;
   localparam int GAP_W    = 8;
   localparam int COUNT_W  = 5;

   // Gap threshold after reset, in seconds.
   localparam logic [GAP_W-1:0] GAP_RESET = 8'd3;

   // Operation codes. The fourth code is unused; its response carries only the entry count, all other fields zero.
   localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]     opcode;
      logic [ACTION_W-1:0] event_action;
      logic [AREA_W-1:0]   area_type;
      logic [TIME_W-1:0]   now_seconds;
      logic [AGE_W-1:0]    entry_age;
   } req_payload_type;

   typedef struct packed {
      logic                notify;
      logic                found;
      logic [ACTION_W-1:0] out_action;
      logic [AREA_W-1:0]   out_area_type;
      logic [TIME_W-1:0]   first_seconds;
      logic [TIME_W-1:0]   update_seconds;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_payload_type;

   // One slot of the history ring.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [AREA_W-1:0]   area;
      logic [TIME_W-1:0]   first_time;
      logic [TIME_W-1:0]   update_time;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic exec;
      logic scan_step;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic is_find;
      logic match;
      logic scan_last;
   } status_type;

endpackage
`default_nettype wire

### sv/ehrd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event history ring channel interfaces
// Valid/ready channels for requests, responses and the register write port.
// ----------------------------------------------------------------------------
interface ehrd_req_if;
   logic                      valid;
   logic                      ready;
   ehrd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ehrd_rsp_if;
   logic                      valid;
   logic                      ready;
   ehrd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ehrd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ehrd_pkg::GAP_W-1:0]      data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/event_history_ring_with_dedup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event history ring with de-duplication
// Ring of timestamped action events with record, read-by-age and find.
// ----------------------------------------------------------------------------
// After reset the block sweeps its entry memory to zero, one slot per cycle,
// and takes no request until the sweep is done; register writes are accepted
// at any time. One request is processed at a time. For a record or a read,
// the memory is read at the accepting edge, the execute state then evaluates
// into the result register, and the done state loads the response register
// once it is empty or being drained. The controller returns to idle only
// after that load, so the next request waits until the response is loaded.
// A find reads one slot per cycle from the newest backward through the single
// memory read port until it finds a match or has read every slot, and its
// response is loaded after that. A new request is taken while a finished
// response still waits to be consumed.
// ----------------------------------------------------------------------------
module event_history_ring_with_dedup #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   ehrd_req_if.sink    req_chan,
   ehrd_rsp_if.source  rsp_chan,
   ehrd_csr_if.sink    csr_chan
);

   ehrd_pkg::cmd_type    cmd;
   ehrd_pkg::status_type status;

   // The gap register can be written at any time.
   assign csr_chan.ready = 1'b1;

   // Controller.
   ehrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   ehrd_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_chan.payload),
      .csr_write   (csr_chan.valid),
      .csr_data    (csr_chan.data),
      .rsp_payload (rsp_chan.payload)
   );

`ifndef SYNTHESIS
   // A transaction keeps the block busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted on two consecutive cycles");

   // The response register is only loaded when it is empty or being drained.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response overwritten before it was consumed");

   // A response appears only after a load command.
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.load_rsp))
      else $error("response valid without a load");

   // Controller commands are mutually exclusive phases.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.capture, cmd.exec, cmd.load_rsp}))
      else $error("conflicting controller commands");
`endif

endmodule
`default_nettype wire

### sv/ehrd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event history ring controller
// Sequences the clearing pass, request capture, evaluation and the find scan,
// and owns the response valid flag.
// ----------------------------------------------------------------------------
module ehrd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ehrd_pkg::status_type status,
   output ehrd_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   // The response register can be loaded when empty or drained this cycle.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Commands decoded from the current state.
   always_comb begin
      cmd            = '0;
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.capture    = (state_ff == ST_IDLE) && req_valid;
      cmd.exec       = (state_ff == ST_EXEC);
      cmd.scan_step  = (state_ff == ST_EXEC) && status.is_find && !status.match &&
                       !status.scan_last;
      cmd.load_rsp   = (state_ff == ST_DONE) && slot_free;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (!cmd.scan_step) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### sv/ehrd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event history ring datapath
// Holds the entry memory, head pointer, fill count, repeat flag, gap register
// and the result registers, and evaluates each operation under command.
// ----------------------------------------------------------------------------
module ehrd_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ehrd_pkg::cmd_type             cmd,
   output ehrd_pkg::status_type          status,
   input  ehrd_pkg::req_payload_type     req_payload,
   input  logic                          csr_write,
   input  logic [ehrd_pkg::GAP_W-1:0]    csr_data,
   output ehrd_pkg::rsp_payload_type     rsp_payload
);

   localparam int AW     = $clog2(DEPTH);
   localparam int CW     = $clog2(DEPTH + 1);
   localparam int AGE_N  = 2 ** ehrd_pkg::AGE_W;
   localparam int OUT_CW = ehrd_pkg::COUNT_W;
   localparam int TW     = ehrd_pkg::TIME_W;

   // Entry memory with a registered read port.
   ehrd_pkg::entry_type mem [DEPTH];
   ehrd_pkg::entry_type rd_data_ff;
   ehrd_pkg::entry_type wr_data;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic                wr_en;

   // Control state of the ring.
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          seen_ff, seen_in;
   logic [ehrd_pkg::GAP_W-1:0] gap_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] scan_addr_ff;
   logic [AW-1:0] scan_cnt_ff;

   // Captured request.
   logic [ehrd_pkg::OP_W-1:0]     op_ff;
   logic [ehrd_pkg::ACTION_W-1:0] act_ff;
   logic [ehrd_pkg::AREA_W-1:0]   area_ff;
   logic [TW-1:0]                 now_ff;

   // Result staging and output register.
   ehrd_pkg::rsp_payload_type res_ff, res_in;
   ehrd_pkg::rsp_payload_type rsp_payload_ff;

   logic [AW-1:0] age_mod [AGE_N];
   logic [AW-1:0] age_sel;
   logic [AW:0]   age_diff;
   logic [AW-1:0] age_slot;
   logic [AW-1:0] head_next;
   logic [AW-1:0] scan_prev;
   logic [TW-1:0] gap_diff;
   logic          gap_fires;
   logic          match;

   // Age reduced modulo the depth, as a constant table.
   for (genvar i = 0; i < AGE_N; i++) begin : g_age_mod
      assign age_mod[i] = AW'(i % DEPTH);
   end

   // Slot that lies the requested age behind the head, with wrap.
   assign age_sel  = age_mod[req_payload.entry_age];
   assign age_diff = {1'b0, head_ff} - {1'b0, age_sel};
   assign age_slot = (head_ff >= age_sel) ? age_diff[AW-1:0]
                                          : AW'(age_diff + (AW+1)'(DEPTH));

   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign scan_prev = (scan_addr_ff == '0) ? AW'(DEPTH - 1) : scan_addr_ff - 1'b1;

   // Gap rule: the difference is read as signed, so a negative gap never fires.
   assign gap_diff  = now_ff - rd_data_ff.update_time;
   assign gap_fires = !gap_diff[TW-1] && (gap_diff >= TW'(gap_ff));
   assign match     = (rd_data_ff.action == act_ff);

   assign status.clear_last = (clr_addr_ff == AW'(DEPTH - 1));
   assign status.is_find    = (op_ff == ehrd_pkg::OP_FIND);
   assign status.match      = match;
   assign status.scan_last  = (scan_cnt_ff == AW'(DEPTH - 1));

   // Read address: the head or the aged slot at capture, the next older slot in a scan.
   always_comb begin
      if (cmd.capture) begin
         rd_addr = (req_payload.opcode == ehrd_pkg::OP_READ) ? age_slot : head_ff;
      end else begin
         rd_addr = scan_prev;
      end
   end

   // Operation evaluation, memory write selection and state updates.
   always_comb begin
      res_in   = '0;
      head_in  = head_ff;
      count_in = count_ff;
      seen_in  = seen_ff;
      wr_en    = 1'b0;
      wr_addr  = clr_addr_ff;
      wr_data  = '0;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.exec) begin
         case (op_ff)
            ehrd_pkg::OP_RECORD: begin
               if (match) begin
                  // Repeat of the newest entry: refresh its update time only.
                  wr_en               = 1'b1;
                  wr_addr             = head_ff;
                  wr_data             = rd_data_ff;
                  wr_data.update_time = now_ff;
                  if (!seen_ff && gap_fires) begin
                     seen_in       = 1'b1;
                     res_in.notify = 1'b1;
                  end
               end else begin
                  // New event: advance the head and write a fresh entry.
                  wr_en               = 1'b1;
                  wr_addr             = head_next;
                  wr_data.action      = act_ff;
                  wr_data.area        = area_ff;
                  wr_data.first_time  = now_ff;
                  wr_data.update_time = now_ff;
                  head_in             = head_next;
                  if (count_ff != CW'(DEPTH)) begin
                     count_in = count_ff + 1'b1;
                  end
                  res_in.notify = gap_fires;
               end
            end
            ehrd_pkg::OP_READ: begin
               res_in.out_action     = rd_data_ff.action;
               res_in.out_area_type  = rd_data_ff.area;
               res_in.first_seconds  = rd_data_ff.first_time;
               res_in.update_seconds = rd_data_ff.update_time;
            end
            ehrd_pkg::OP_FIND: begin
               if (match) begin
                  res_in.found          = 1'b1;
                  res_in.out_action     = rd_data_ff.action;
                  res_in.out_area_type  = rd_data_ff.area;
                  res_in.first_seconds  = rd_data_ff.first_time;
                  res_in.update_seconds = rd_data_ff.update_time;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Entry memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Ring control state and the gap register.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= AW'(DEPTH - 1);
         count_ff    <= '0;
         seen_ff     <= 1'b0;
         gap_ff      <= ehrd_pkg::GAP_RESET;
         clr_addr_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         seen_ff  <= seen_in;
         if (csr_write) begin
            gap_ff <= csr_data;
         end
         if (cmd.clear_step && !status.clear_last) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // Request capture, scan position and result registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_payload.opcode;
         act_ff       <= req_payload.event_action;
         area_ff      <= req_payload.area_type;
         now_ff       <= req_payload.now_seconds;
         scan_addr_ff <= head_ff;
         scan_cnt_ff  <= '0;
      end else if (cmd.scan_step) begin
         scan_addr_ff <= scan_prev;
         scan_cnt_ff  <= scan_cnt_ff + 1'b1;
      end
      if (cmd.exec) begin
         res_ff <= res_in;
      end
      if (cmd.load_rsp) begin
         rsp_payload_ff             <= res_ff;
         rsp_payload_ff.entry_count <= OUT_CW'(count_ff);
      end
   end

   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire
